### sv/kms_pkg.sv
// ----------------------------------------------------------------------------
// kms_pkg
// shared types, constants and character tables for the keyboard matrix scanner
// ----------------------------------------------------------------------------
package kms_pkg;

  localparam int unsigned NumRows   = 5;
  localparam int unsigned NumCols   = 10;
  localparam int unsigned LineCols  = 10;
  localparam int unsigned TableSize = 50;

  localparam int unsigned PhaseW = 3;
  localparam int unsigned KeyW   = 6;
  localparam int unsigned CharW  = 8;
  localparam int unsigned ColW   = 4;

  typedef logic [PhaseW-1:0] phase_t;
  typedef logic [KeyW-1:0]   key_t;
  typedef logic [CharW-1:0]  char_t;
  typedef logic [ColW-1:0]   col_t;

  localparam key_t KeyNone = key_t'(TableSize);

  typedef enum logic [1:0] {
    SHIFT_NONE  = 2'd0,
    SHIFT_LEFT  = 2'd1,
    SHIFT_RIGHT = 2'd2
  } shift_e;

  localparam char_t NavUp  = 8'h80;
  localparam char_t NavDn  = 8'h81;
  localparam char_t NavLt  = 8'h82;
  localparam char_t NavRt  = 8'h83;
  localparam char_t NavDel = 8'h84;
  localparam char_t NavEnt = 8'h0A;
  localparam char_t NavEcr = 8'h0D;
  localparam char_t NavBs  = 8'h08;

  localparam char_t PlainTbl [TableSize] = '{
    "3", "4", "2", "5", "1", "9", "6", "7", "0", "8",
    "e", "r", "w", "t", "q", "o", "y", "u", "p", "i",
    "s", "d", "a", "f", "/", "k", "g", "h", "l", "j",
    "x", "c", "z", "v", " ", 8'h2C, "b", "n", ".", "m",
    NavDn, NavRt, NavLt, ";", NavUp, NavDel, "=", NavEnt, NavBs, "-"
  };

  localparam char_t LeftTbl [TableSize] = '{
    "#", "$", "@", "%", "!", "(", " ", "&", ")", "*",
    "E", "R", "W", "T", "Q", "O", "Y", "U", "P", "I",
    "S", "D", "A", "F", "?", "K", "G", "H", "L", "J",
    "X", "C", "Z", "V", " ", "<", "B", "N", ">", "M",
    NavDn, NavRt, NavLt, ":", NavUp, NavDel, "+", NavEcr, NavBs, "_"
  };

  localparam char_t RightTbl [TableSize] = '{
    "#", "$", "@", "%", "!", "(", " ", "&", ")", "*",
    "E", "R", "W", "T", "Q", "O", "Y", "U", "P", "I",
    "S", "D", "A", "F", "?", "K", "G", "H", "L", "J",
    "X", "C", "Z", "V", " ", "<", "B", "N", ">", "M",
    NavDn, NavRt, NavLt, ":", NavUp, NavDel, "+", NavEcr, NavBs, "\""
  };

  // positions beyond the tables give a zero character
  function automatic char_t key_to_char(key_t key, shift_e sel);
    char_t ch;
    ch = '0;
    if (key < KeyNone) begin
      case (sel)
        SHIFT_LEFT:  ch = LeftTbl[key];
        SHIFT_RIGHT: ch = RightTbl[key];
        default:     ch = PlainTbl[key];
      endcase
    end
    return ch;
  endfunction

endpackage

### sv/keyboard_matrix_scanner_top.sv
// ----------------------------------------------------------------------------
// keyboard_matrix_scanner_top
// row-by-row key matrix scanner with a decode tick that turns a new key into
// a character through the normal, left-shift or right-shift table
// ----------------------------------------------------------------------------
//  channel   dir  tdata fields (lsb first)
//  s_axis    in   column_lines_n[9:0], shift_left_n[10], shift_right_n[11]
//  m_axis    out  row_to_drive[2:0], key_valid[3], char_code[11:4],
//                 key_index[17:12], shift_used[19:18]
//
//  one tick per clock while the output is not stalled; each result is registered in the cycle after its tick
//  a full scan is five row ticks and one decode tick
//  reset: first row phase, held and previous key none, result register empty
//  the input is taken while the result register is empty or being emptied
// ----------------------------------------------------------------------------
module keyboard_matrix_scanner_top
  import kms_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // column_lines_n[9:0], shift_left_n[10], shift_right_n[11], zero fill
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // row_to_drive[2:0], key_valid[3], char_code[11:4], key_index[17:12],
  // shift_used[19:18], zero fill
  output logic [23:0] m_axis_tdata
);

  phase_t phase_q, phase_d;
  key_t   held_q, held_d;
  key_t   prev_q, prev_d;

  logic   out_valid_q;
  phase_t row_q, row_d;
  logic   kvalid_q, kvalid_d;
  char_t  kchar_q, kchar_d;
  key_t   kidx_q;
  shift_e used_q, used_d;

  logic [LineCols-1:0] cols_n;
  logic                shl_n, shr_n;
  logic                accept;
  logic                col_hit;
  col_t                col_idx;

  assign cols_n = s_axis_tdata[LineCols-1:0];
  assign shl_n  = s_axis_tdata[LineCols];
  assign shr_n  = s_axis_tdata[LineCols+1];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // highest low column wins
  always_comb begin
    col_hit = 1'b0;
    col_idx = '0;
    for (int c = 0; c < NumCols && c < LineCols; c++) begin
      if (!cols_n[c]) begin
        col_hit = 1'b1;
        col_idx = col_t'(c);
      end
    end
  end

  always_comb begin
    phase_d  = phase_q;
    held_d   = held_q;
    prev_d   = prev_q;
    kvalid_d = 1'b0;
    kchar_d  = '0;
    used_d   = SHIFT_NONE;
    if (phase_q < phase_t'(NumRows)) begin
      if (phase_q == '0) begin
        held_d = KeyNone;
      end
      if (col_hit) begin
        held_d = key_t'(KeyW'(col_idx) + KeyW'(phase_q) * KeyW'(NumCols));
      end
      phase_d = phase_q + phase_t'(1);
    end else begin
      if (held_q != KeyNone && held_q != prev_q) begin
        kvalid_d = 1'b1;
        if (!shl_n) begin
          used_d = SHIFT_LEFT;
        end else if (!shr_n) begin
          used_d = SHIFT_RIGHT;
        end
        kchar_d = key_to_char(held_q, used_d);
      end
      prev_d  = held_q;
      phase_d = '0;
    end
    row_d = phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      held_q      <= KeyNone;
      prev_q      <= KeyNone;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q     <= phase_d;
        held_q      <= held_d;
        prev_q      <= prev_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      row_q    <= row_d;
      kvalid_q <= kvalid_d;
      kchar_q  <= kchar_d;
      kidx_q   <= held_d;
      used_q   <= used_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, used_q, kidx_q, kchar_q, kvalid_q, row_q};

endmodule

### tb/sv/keyboard_matrix_scanner_top_tb.sv
// ----------------------------------------------------------------------------
// keyboard_matrix_scanner_top_tb
// self-checking bench: drives scan ticks with random gaps, predicts each
// result word from its own scan and decode model, and checks every word the
// scanner sends under random and long back-pressure
// ----------------------------------------------------------------------------
module keyboard_matrix_scanner_top_tb
  import kms_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ScanW      = NumRows * LineCols;

  typedef struct packed {
    phase_t row;
    logic   vld;
    char_t  ch;
    key_t   idx;
    shift_e used;
  } scan_word_t;

  localparam logic [8*40-1:0] PlainAlpha   = "3425196708erwtqoyupisdaf/kghljxczv ,bn.m";
  localparam logic [8*40-1:0] ShiftedAlpha = "#$@%!( &)*ERWTQOYUPISDAF?KGHLJXCZV <BN>M";

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_axis_tready;
  // column_lines_n[9:0], shift_left_n[10], shift_right_n[11], zero fill
  logic [15:0] s_tdata;
  logic        m_axis_tvalid;
  logic        m_tready;
  // row_to_drive[2:0], key_valid[3], char_code[11:4], key_index[17:12],
  // shift_used[19:18], zero fill
  logic [23:0] m_axis_tdata;

  phase_t     pred_row;
  key_t       pred_key;
  key_t       pred_prev_key;
  scan_word_t pending_words [$];
  scan_word_t want;

  bit          idle_on;
  int unsigned hold_left;
  int unsigned stall_left;
  int unsigned cycle_count;
  int unsigned errors;
  int unsigned ticks_sent;
  int unsigned words_checked;
  int unsigned keys_seen;

  keyboard_matrix_scanner_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic char_t char_code_of(key_t key, shift_e sel);
    char_t ch;
    bit    shifted;
    ch = '0;
    shifted = (sel != SHIFT_NONE);
    if (key < 40) begin
      ch = shifted ? ShiftedAlpha[8*(39-key) +: 8] : PlainAlpha[8*(39-key) +: 8];
    end else if (key < 50) begin
      case (key - 40)
        0: ch = NavDn;
        1: ch = NavRt;
        2: ch = NavLt;
        3: ch = shifted ? ":" : ";";
        4: ch = NavUp;
        5: ch = NavDel;
        6: ch = shifted ? "+" : "=";
        7: ch = shifted ? NavEcr : NavEnt;
        8: ch = NavBs;
        default: begin
          if (sel == SHIFT_LEFT) ch = "_";
          else if (sel == SHIFT_RIGHT) ch = "\"";
          else ch = "-";
        end
      endcase
    end
    return ch;
  endfunction

  task automatic predict_tick(input logic [9:0] cols, input logic sl_n, input logic sr_n);
    scan_word_t w;
    w = '0;
    w.used = SHIFT_NONE;
    if (pred_row < NumRows) begin
      if (pred_row == 0) pred_key = KeyNone;
      for (int c = 0; c < NumCols; c++) begin
        if (c < LineCols && !cols[c]) pred_key = key_t'(c + pred_row * NumCols);
      end
      pred_row = pred_row + 1'b1;
    end else begin
      if (pred_key != KeyNone && pred_key != pred_prev_key) begin
        w.vld = 1'b1;
        if (!sl_n) w.used = SHIFT_LEFT;
        else if (!sr_n) w.used = SHIFT_RIGHT;
        w.ch = char_code_of(pred_key, w.used);
      end
      pred_prev_key = pred_key;
      pred_row = '0;
    end
    w.row = pred_row;
    w.idx = pred_key;
    pending_words.push_back(w);
  endtask

  task automatic send_tick(input logic [9:0] cols, input logic sl_n, input logic sr_n);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk_i);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, sr_n, sl_n, cols};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_tick(cols, sl_n, sr_n);
    ticks_sent++;
  endtask

  // five row ticks then the decode tick; shift lines only matter on decode
  task automatic send_scan(input logic [ScanW-1:0] scan_cols, input logic [1:0] dec_shift_n);
    for (int r = 0; r < NumRows; r++) begin
      send_tick(scan_cols[r*LineCols +: LineCols], 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    end
    send_tick(10'($urandom_range(0, 1023)), dec_shift_n[0], dec_shift_n[1]);
  endtask

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    errors++;
    if (errors <= 100) begin
      $display("mismatch on word %0d: %s got %0d expected %0d", words_checked, what, got,
               exp_val);
    end
  endtask

  task automatic test_directed();
    logic [ScanW-1:0] sc;
    sc = '1;
    sc[2*LineCols + 0] = 1'b0;
    send_scan(sc, 2'b11);
    // same key still held, nothing new
    send_scan(sc, 2'b10);
    sc = '1;
    sc[0*LineCols + 3] = 1'b0;
    sc[4*LineCols +: LineCols] = '0;
    send_scan(sc, 2'b01);
    sc = '1;
    sc[1*LineCols +: LineCols] = '0;
    send_scan(sc, 2'b00);
  endtask

  task automatic test_random_keys(input int unsigned n_scans);
    logic [ScanW-1:0] sc;
    int unsigned      mode;
    int unsigned      key;
    int unsigned      last_key;
    last_key = 0;
    for (int unsigned s = 0; s < n_scans; s++) begin
      sc = '1;
      mode = $urandom_range(0, 99);
      if (mode < 15) begin
        sc = '1;
      end else if (mode < 55) begin
        key = ($urandom_range(0, 1) != 0) ? last_key : $urandom_range(0, 49);
        sc[key] = 1'b0;
        last_key = key;
      end else if (mode < 70) begin
        sc[$urandom_range(0, 49)] = 1'b0;
        sc[$urandom_range(0, 49)] = 1'b0;
      end else begin
        for (int r = 0; r < NumRows; r++) begin
          sc[r*LineCols +: LineCols] = 10'($urandom_range(0, 1023));
        end
      end
      send_scan(sc, 2'($urandom_range(0, 3)));
    end
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_left = 300;
    test_random_keys(20);
    while (hold_left != 0) @(posedge clk_i);
    idle_on = 1'b1;
  endtask

  task automatic test_streaming();
    idle_on = 1'b0;
    test_random_keys(15);
  endtask

  initial begin
    m_tready = 1'b0;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_tready) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word", m_axis_tdata, 0);
      end else begin
        want = pending_words.pop_front();
        if (m_axis_tdata[2:0] != want.row) report_mismatch("row_to_drive", m_axis_tdata[2:0],
                                                           want.row);
        if (m_axis_tdata[3] != want.vld) report_mismatch("key_valid", m_axis_tdata[3],
                                                         want.vld);
        if (m_axis_tdata[11:4] != want.ch) report_mismatch("char_code", m_axis_tdata[11:4],
                                                           want.ch);
        if (m_axis_tdata[17:12] != want.idx) report_mismatch("key_index", m_axis_tdata[17:12],
                                                             want.idx);
        if (m_axis_tdata[19:18] != want.used) report_mismatch("shift_used",
                                                              m_axis_tdata[19:18], want.used);
        if (want.vld) keys_seen++;
      end
      words_checked++;
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    idle_on = 1'b1;
    hold_left = 0;
    errors = 0;
    ticks_sent = 0;
    words_checked = 0;
    keys_seen = 0;
    pred_row = '0;
    pred_key = KeyNone;
    pred_prev_key = KeyNone;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_keys(280);
    test_backpressure();
    test_streaming();

    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);

    $display("%0d scan ticks sent, %0d result words checked, %0d new keys decoded", ticks_sent,
             words_checked, keys_seen);
    $display("covered all shift tables, repeated keys, multi-key rows and long output stalls");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
